### hw/rtl/gpsrp_pkg.sv
package gpsrp_pkg;

    // Framing bytes of the receiver's report protocol.
    localparam logic [7:0] LEAD_BYTE   = 8'h10;
    localparam logic [7:0] ID_HEALTH   = 8'h46;
    localparam logic [7:0] ID_TIME     = 8'h41;
    localparam logic [7:0] ID_POSITION = 8'h4A;

    // Payload lengths in bytes.
    localparam logic [4:0] SIZE_HEALTH   = 5'd2;
    localparam logic [4:0] SIZE_TIME     = 5'd10;
    localparam logic [4:0] SIZE_POSITION = 5'd20;

    localparam int NUM_WORDS = 3;
    localparam int TDATA_W   = 184;

    // Output report kinds carried on tuser.
    localparam logic REPORT_TIME     = 1'b0;
    localparam logic REPORT_POSITION = 1'b1;

    typedef enum logic [1:0] {
        KIND_HEALTH   = 2'd0,
        KIND_TIME     = 2'd1,
        KIND_POSITION = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'b001,
        PH_LEAD    = 3'b010,
        PH_PAYLOAD = 3'b100
    } phase_t;

    typedef struct packed {
        logic        report_kind;
        logic [31:0] time_of_week;
        logic [15:0] week_number;
        logic [31:0] utc_offset;
        logic [31:0] latitude;
        logic [31:0] longitude;
        logic [31:0] altitude;
        logic        receiver_healthy;
        logic        fix_complete;
    } report_t;

    function automatic logic [4:0] payload_size(input kind_t kind);
        logic [4:0] size;
        case (kind)
            KIND_TIME:     size = SIZE_TIME;
            KIND_POSITION: size = SIZE_POSITION;
            default:       size = SIZE_HEALTH;
        endcase
        return size;
    endfunction

endpackage

### hw/rtl/gpsrp_parser.sv
module gpsrp_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                byte_valid,
    input  logic [7:0]          rx_byte,
    output logic                res_valid,
    output gpsrp_pkg::report_t  res
);
    import gpsrp_pkg::*;

    phase_t      phase_reg, phase_next;
    kind_t       kind_reg, kind_next;
    logic [4:0]  count_reg, count_next;
    logic [31:0] words_reg [NUM_WORDS];
    logic [31:0] words_next [NUM_WORDS];
    logic        healthy_reg, healthy_next;
    logic        have_time_reg, have_time_next;
    logic        have_pos_reg, have_pos_next;

    logic        slot_hit;
    logic [1:0]  slot;
    logic [4:0]  count_plus;

    // Which assembled word the current payload byte shifts into.
    always_comb begin
        slot_hit = 1'b0;
        slot     = 2'd0;
        case (kind_reg)
            KIND_TIME: begin
                if (count_reg < 5'd4) begin
                    slot_hit = 1'b1;
                    slot     = 2'd0;
                end else if (count_reg < 5'd6) begin
                    slot_hit = 1'b1;
                    slot     = 2'd1;
                end else if (count_reg < 5'd10) begin
                    slot_hit = 1'b1;
                    slot     = 2'd2;
                end
            end
            KIND_POSITION: begin
                if (count_reg < 5'd12) begin
                    slot_hit = 1'b1;
                    slot     = count_reg[3:2];
                end
            end
            default: begin
                slot_hit = 1'b0;
            end
        endcase
    end

    assign count_plus = count_reg + 5'd1;

    always_comb begin
        phase_next     = phase_reg;
        kind_next      = kind_reg;
        count_next     = count_reg;
        words_next     = words_reg;
        healthy_next   = healthy_reg;
        have_time_next = have_time_reg;
        have_pos_next  = have_pos_reg;
        res_valid      = 1'b0;
        res            = '0;

        if (byte_valid) begin
            unique case (phase_reg)
                PH_LEAD: begin
                    if (rx_byte == ID_HEALTH || rx_byte == ID_TIME
                            || rx_byte == ID_POSITION) begin
                        kind_next  = (rx_byte == ID_HEALTH) ? KIND_HEALTH :
                                     (rx_byte == ID_TIME)   ? KIND_TIME : KIND_POSITION;
                        count_next = '0;
                        for (int i = 0; i < NUM_WORDS; i++) begin
                            words_next[i] = '0;
                        end
                        phase_next = PH_PAYLOAD;
                    end else if (rx_byte != LEAD_BYTE) begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_PAYLOAD: begin
                    if (slot_hit) begin
                        words_next[slot] = {words_reg[slot][23:0], rx_byte};
                    end
                    if (kind_reg == KIND_HEALTH && count_reg == 5'd0 && rx_byte == 8'h00) begin
                        healthy_next = 1'b1;
                    end
                    count_next = count_plus;
                    if (count_plus >= payload_size(kind_reg)) begin
                        phase_next = PH_HUNT;
                        count_next = '0;
                        if (kind_reg == KIND_TIME && healthy_reg) begin
                            have_time_next       = 1'b1;
                            res_valid            = 1'b1;
                            res.report_kind      = REPORT_TIME;
                            res.time_of_week     = words_next[0];
                            res.week_number      = words_next[1][15:0];
                            res.utc_offset       = words_next[2];
                            res.receiver_healthy = healthy_reg;
                            res.fix_complete     = have_pos_reg;
                        end else if (kind_reg == KIND_POSITION) begin
                            have_pos_next        = 1'b1;
                            res_valid            = 1'b1;
                            res.report_kind      = REPORT_POSITION;
                            res.latitude         = words_next[0];
                            res.longitude        = words_next[1];
                            res.altitude         = words_next[2];
                            res.receiver_healthy = healthy_reg;
                            res.fix_complete     = have_time_reg;
                        end
                    end
                end
                default: begin
                    phase_next = (rx_byte == LEAD_BYTE) ? PH_LEAD : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT;
            kind_reg      <= KIND_HEALTH;
            count_reg     <= '0;
            healthy_reg   <= 1'b0;
            have_time_reg <= 1'b0;
            have_pos_reg  <= 1'b0;
            for (int i = 0; i < NUM_WORDS; i++) begin
                words_reg[i] <= '0;
            end
        end else begin
            phase_reg     <= phase_next;
            kind_reg      <= kind_next;
            count_reg     <= count_next;
            healthy_reg   <= healthy_next;
            have_time_reg <= have_time_next;
            have_pos_reg  <= have_pos_next;
            words_reg     <= words_next;
        end
    end

endmodule

### hw/rtl/gps_report_packet_parser_top.sv
// Channel   Direction  tdata (low bit first)                          tuser
// s_        in         rx_byte[7:0]                                   -
// m_        out        time_of_week[31:0], week_number[15:0],         report_kind
//                      utc_offset[31:0], latitude[31:0],
//                      longitude[31:0], altitude[31:0],
//                      receiver_healthy, fix_complete, 6 zero bits
//
// One byte word is accepted per cycle unless the input stalls. The byte that
// completes a position report, or a time report once healthy, is decoded in
// the same cycle; its report word appears on the m_ side at the next edge.
// Reset is synchronous on aresetn and returns the parser to hunting with all
// flags cleared. The input stalls only while a report word is held in the
// output register and the downstream side is not taking it.
module gps_report_packet_parser_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // rx_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [gpsrp_pkg::TDATA_W-1:0]      m_tdata,   // see table above
    output logic                               m_tuser    // report_kind
);
    import gpsrp_pkg::*;

    logic    s_fire;
    logic    res_valid;
    report_t res;
    logic    out_valid_reg;
    report_t out_reg;

    // The output register frees itself in the same cycle it is drained, so a
    // byte can be taken even while a finished report is being handed off.
    assign s_tready = !out_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    gpsrp_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (s_fire),
        .rx_byte    (s_tdata),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_fire) begin
            out_valid_reg <= res_valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Report payload needs no reset; it is only looked at while valid.
    always_ff @(posedge aclk) begin
        if (s_fire && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.report_kind;
    assign m_tdata  = {6'b0,
                       out_reg.fix_complete,
                       out_reg.receiver_healthy,
                       out_reg.altitude,
                       out_reg.longitude,
                       out_reg.latitude,
                       out_reg.utc_offset,
                       out_reg.week_number,
                       out_reg.time_of_week};

    // A fix needs a time report, which is only given once healthy.
    a_fix_implies_healthy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[177] |-> m_tdata[176])
        else $error("fix reported without a healthy receiver");

    a_time_needs_health: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == REPORT_TIME |-> m_tdata[176])
        else $error("time report given while receiver not healthy");

    a_position_time_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == REPORT_POSITION |-> m_tdata[79:0] == 80'd0)
        else $error("position report carries time fields");

    a_report_from_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("report appeared without an accepted byte");

endmodule

### tb/gpsrp_checker.sv
`timescale 1ns / 100ps

// Watches both stream channels of the report parser, keeps its own model of
// the parse state and compares every report word with the oldest one due.
module gpsrp_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // rx_byte
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [gpsrp_pkg::TDATA_W-1:0] m_tdata,   // time_of_week .. fix_complete
    input  logic                          m_tuser,   // report_kind
    output int                            mismatch_count,
    output int                            reports_outstanding
);

    gpsrp_pkg::phase_t  phase;
    gpsrp_pkg::kind_t   kind;
    logic [4:0]         byte_index;
    logic [31:0]        words [3];
    logic               healthy;
    logic               seen_time;
    logic               seen_position;

    gpsrp_pkg::report_t expected_reports [$];

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%0s mismatch: expected %h, actual %h", name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    // Advances the parse state by one received byte and queues the report
    // word that the byte completes, if any.
    task automatic parse_rx_byte(input logic [7:0] rx);
        int                 slot;
        logic [4:0]         size;
        gpsrp_pkg::report_t rep;
        case (phase)
            gpsrp_pkg::PH_LEAD: begin
                if (rx == gpsrp_pkg::ID_HEALTH || rx == gpsrp_pkg::ID_TIME ||
                        rx == gpsrp_pkg::ID_POSITION) begin
                    if (rx == gpsrp_pkg::ID_HEALTH)
                        kind = gpsrp_pkg::KIND_HEALTH;
                    else if (rx == gpsrp_pkg::ID_TIME)
                        kind = gpsrp_pkg::KIND_TIME;
                    else
                        kind = gpsrp_pkg::KIND_POSITION;
                    byte_index = '0;
                    words[0] = '0;
                    words[1] = '0;
                    words[2] = '0;
                    phase = gpsrp_pkg::PH_PAYLOAD;
                end else if (rx != gpsrp_pkg::LEAD_BYTE) begin
                    phase = gpsrp_pkg::PH_HUNT;
                end
            end
            gpsrp_pkg::PH_PAYLOAD: begin
                slot = 3;
                if (kind == gpsrp_pkg::KIND_TIME) begin
                    if (byte_index < 5'd4)
                        slot = 0;
                    else if (byte_index < 5'd6)
                        slot = 1;
                    else if (byte_index < 5'd10)
                        slot = 2;
                end else if (kind == gpsrp_pkg::KIND_POSITION && byte_index < 5'd12) begin
                    slot = int'(byte_index) / 4;
                end
                if (slot < 3)
                    words[slot] = {words[slot][23:0], rx};
                // Only the status byte of a health report matters.
                if (kind == gpsrp_pkg::KIND_HEALTH && byte_index == 5'd0 && rx == 8'h00)
                    healthy = 1'b1;
                byte_index = byte_index + 5'd1;

                case (kind)
                    gpsrp_pkg::KIND_TIME:     size = gpsrp_pkg::SIZE_TIME;
                    gpsrp_pkg::KIND_POSITION: size = gpsrp_pkg::SIZE_POSITION;
                    default:                  size = gpsrp_pkg::SIZE_HEALTH;
                endcase

                if (byte_index == size) begin
                    phase = gpsrp_pkg::PH_HUNT;
                    byte_index = '0;
                    rep = '0;
                    if (kind == gpsrp_pkg::KIND_TIME && healthy) begin
                        seen_time = 1'b1;
                        rep.report_kind  = gpsrp_pkg::REPORT_TIME;
                        rep.time_of_week = words[0];
                        rep.week_number  = words[1][15:0];
                        rep.utc_offset   = words[2];
                    end else if (kind == gpsrp_pkg::KIND_POSITION) begin
                        seen_position = 1'b1;
                        rep.report_kind = gpsrp_pkg::REPORT_POSITION;
                        rep.latitude    = words[0];
                        rep.longitude   = words[1];
                        rep.altitude    = words[2];
                    end
                    if ((kind == gpsrp_pkg::KIND_TIME && healthy) ||
                            kind == gpsrp_pkg::KIND_POSITION) begin
                        rep.receiver_healthy = healthy;
                        rep.fix_complete     = seen_time && seen_position;
                        expected_reports.push_back(rep);
                    end
                end
            end
            default: begin
                if (rx == gpsrp_pkg::LEAD_BYTE)
                    phase = gpsrp_pkg::PH_LEAD;
                else
                    phase = gpsrp_pkg::PH_HUNT;
            end
        endcase
    endtask

    task automatic check_report(input gpsrp_pkg::report_t exp_rep);
        check_field("report_kind", 32'(exp_rep.report_kind), 32'(m_tuser));
        check_field("time_of_week", exp_rep.time_of_week, m_tdata[31:0]);
        check_field("week_number", 32'(exp_rep.week_number), 32'(m_tdata[47:32]));
        check_field("utc_offset", exp_rep.utc_offset, m_tdata[79:48]);
        check_field("latitude", exp_rep.latitude, m_tdata[111:80]);
        check_field("longitude", exp_rep.longitude, m_tdata[143:112]);
        check_field("altitude", exp_rep.altitude, m_tdata[175:144]);
        check_field("receiver_healthy", 32'(exp_rep.receiver_healthy), 32'(m_tdata[176]));
        check_field("fix_complete", 32'(exp_rep.fix_complete), 32'(m_tdata[177]));
        check_field("tdata padding", 32'h0, 32'(m_tdata[183:178]));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            phase = gpsrp_pkg::PH_HUNT;
            kind = gpsrp_pkg::KIND_HEALTH;
            byte_index = '0;
            words[0] = '0;
            words[1] = '0;
            words[2] = '0;
            healthy = 1'b0;
            seen_time = 1'b0;
            seen_position = 1'b0;
            mismatch_count = 0;
            expected_reports.delete();
            reports_outstanding <= 0;
        end else begin
            if (s_tvalid && s_tready)
                parse_rx_byte(s_tdata);
            if (m_tvalid && m_tready) begin
                if (expected_reports.size() == 0) begin
                    $error("report word with none expected: tuser %b tdata %h",
                           m_tuser, m_tdata);
                    mismatch_count++;
                end else begin
                    check_report(expected_reports.pop_front());
                end
            end
            reports_outstanding <= expected_reports.size();
        end
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

// Top of the report parser testbench. It builds a byte stream of directed
// and random receiver traffic, feeds it into the parser word by word with
// random gaps, drives the downstream ready with random stalls, and gives
// the verdict. All prediction and comparison lives in the checker.
module tb_top;

    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_BYTES = 725;
    // The last stretch of the stream runs with no idling on either side.
    localparam int CALM_TAIL    = 150;
    // Start and length of the long downstream hold-off.
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    // Fill code for a payload of random bytes instead of a constant.
    localparam int FILL_RANDOM  = -1;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [7:0]                    s_tdata;   // rx_byte
    logic                          m_tvalid;
    logic                          m_tready;
    logic [gpsrp_pkg::TDATA_W-1:0] m_tdata;   // time_of_week .. fix_complete, padding
    logic                          m_tuser;   // report_kind

    int mismatch_count;
    int reports_outstanding;
    int cycle_count;

    // The whole byte stream is prepared before reset is released.
    logic [7:0] rx_stream [$];
    int         stream_len;
    int         bytes_sent;

    gps_report_packet_parser_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    gpsrp_checker u_checker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tdata             (s_tdata),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata),
        .m_tuser             (m_tuser),
        .mismatch_count      (mismatch_count),
        .reports_outstanding (reports_outstanding)
    );

    initial aclk = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // A random payload byte is a lead byte now and then, so that the parser
    // is seen to treat header-like bytes inside a payload as plain data.
    function automatic logic [7:0] random_payload_byte();
        if ($urandom_range(0, 7) == 0)
            return gpsrp_pkg::LEAD_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    // Appends one complete frame: lead byte, identifier and the payload that
    // the identifier calls for, either all one value or random.
    task automatic add_report(input logic [7:0] id, input int fill);
        int len;
        if (id == gpsrp_pkg::ID_TIME)
            len = int'(gpsrp_pkg::SIZE_TIME);
        else if (id == gpsrp_pkg::ID_POSITION)
            len = int'(gpsrp_pkg::SIZE_POSITION);
        else
            len = int'(gpsrp_pkg::SIZE_HEALTH);
        rx_stream.push_back(gpsrp_pkg::LEAD_BYTE);
        rx_stream.push_back(id);
        for (int k = 0; k < len; k++) begin
            if (fill == FILL_RANDOM)
                rx_stream.push_back(random_payload_byte());
            else
                rx_stream.push_back(8'(fill));
        end
    endtask

    function automatic logic [7:0] random_report_id();
        case ($urandom_range(0, 2))
            0:       return gpsrp_pkg::ID_HEALTH;
            1:       return gpsrp_pkg::ID_TIME;
            default: return gpsrp_pkg::ID_POSITION;
        endcase
    endfunction

    // Sender: builds the stream, releases reset and offers every byte until
    // it is taken. Random gaps come before some of the words, except in
    // every third block of 64 words and in the calm tail.
    initial begin
        int          pick;
        logic [7:0]  junk;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        bytes_sent = 0;

        // Directed traffic. A time report while the receiver is still
        // unhealthy must be swallowed without a word.
        add_report(gpsrp_pkg::ID_TIME, 8'hFF);
        // A position report is always given, here with all-zero content.
        add_report(gpsrp_pkg::ID_POSITION, 8'h00);
        // A health report with a nonzero status leaves the receiver unhealthy.
        add_report(gpsrp_pkg::ID_HEALTH, 8'hFF);
        add_report(gpsrp_pkg::ID_TIME, 8'h5A);
        // Identifiers out of place are ignored while hunting.
        rx_stream.push_back(gpsrp_pkg::ID_TIME);
        rx_stream.push_back(gpsrp_pkg::ID_POSITION);
        rx_stream.push_back(gpsrp_pkg::ID_HEALTH);
        // An unknown identifier drops the pair.
        rx_stream.push_back(gpsrp_pkg::LEAD_BYTE);
        rx_stream.push_back(8'h55);
        // A run of lead bytes still leads into the health report behind it,
        // which carries a zero status and marks the receiver healthy.
        rx_stream.push_back(gpsrp_pkg::LEAD_BYTE);
        rx_stream.push_back(gpsrp_pkg::LEAD_BYTE);
        add_report(gpsrp_pkg::ID_HEALTH, 8'h00);
        // Lead bytes in a payload are data; this time report also completes
        // the fix.
        add_report(gpsrp_pkg::ID_TIME, int'(gpsrp_pkg::LEAD_BYTE));
        add_report(gpsrp_pkg::ID_POSITION, 8'hFF);
        add_report(gpsrp_pkg::ID_TIME, 8'h00);
        // A nonzero status later on does not clear the healthy flag.
        add_report(gpsrp_pkg::ID_HEALTH, 8'h80);
        add_report(gpsrp_pkg::ID_TIME, FILL_RANDOM);
        rx_stream.push_back(8'hFF);
        rx_stream.push_back(8'h00);

        // Random traffic: mostly well-formed frames with random content,
        // the rest repeated lead bytes, unknown identifiers and noise.
        stream_len = rx_stream.size() + RANDOM_BYTES;
        while (rx_stream.size() < stream_len) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                add_report(gpsrp_pkg::ID_POSITION, FILL_RANDOM);
            end else if (pick < 55) begin
                add_report(gpsrp_pkg::ID_TIME, FILL_RANDOM);
            end else if (pick < 65) begin
                add_report(gpsrp_pkg::ID_HEALTH, FILL_RANDOM);
            end else if (pick < 73) begin
                repeat ($urandom_range(1, 3)) rx_stream.push_back(gpsrp_pkg::LEAD_BYTE);
                add_report(random_report_id(), FILL_RANDOM);
            end else if (pick < 81) begin
                do begin
                    junk = 8'($urandom_range(0, 255));
                end while (junk == gpsrp_pkg::LEAD_BYTE || junk == gpsrp_pkg::ID_HEALTH ||
                           junk == gpsrp_pkg::ID_TIME || junk == gpsrp_pkg::ID_POSITION);
                rx_stream.push_back(gpsrp_pkg::LEAD_BYTE);
                rx_stream.push_back(junk);
            end else begin
                repeat ($urandom_range(1, 6)) rx_stream.push_back(8'($urandom_range(0, 255)));
            end
        end
        stream_len = rx_stream.size();

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < stream_len; i++) begin
            if (i < stream_len - CALM_TAIL && (i / 64) % 3 != 2 &&
                    $urandom_range(0, 3) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= rx_stream[i];
            do @(posedge aclk); while (!s_tready);
            bytes_sent++;
        end
        s_tvalid <= 1'b0;

        // The checker first counts the last word taken, then every expected
        // report must drain before the final settle.
        @(posedge aclk);
        while (reports_outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // Receiver: random stalls with calm blocks between.
    // Once, after the sender has passed a few hundred words, ready stays low
    // for a long stretch so that the output register fills and the parser
    // has to hold off its input while the sender keeps offering.
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (!hold_done && bytes_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (bytes_sent < stream_len - CALM_TAIL && (bytes_sent / 80) % 3 != 1 &&
                         $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Watchdog: a hung handshake or a report that never comes ends here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

### files.f
hw/rtl/gpsrp_pkg.sv
hw/rtl/gpsrp_parser.sv
hw/rtl/gps_report_packet_parser_top.sv
tb/gpsrp_checker.sv
tb/tb_top.sv
